// ----- rtl/core/lla_pkg.sv -----
package lla_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int MASK_W = 9;
    localparam int SIZE_W = 11;
    localparam int CFG_DATA_W = SIZE_W;
    localparam int CFG_ADDR_W = 2;
    localparam int TDATA_W = 8;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_BIRTH_MASK   = 2'd0;
    localparam cfg_addr_t REG_SURVIVE_MASK = 2'd1;
    localparam cfg_addr_t REG_GRID_WIDTH   = 2'd2;
    localparam cfg_addr_t REG_GRID_HEIGHT  = 2'd3;

    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1024;

endpackage

// ----- rtl/core/life_like_automaton_step_core.sv -----
// A cell's next state is registered on acceptance of the word that completes its
// 3x3 window, i.e. grid_width + 1 words after the cell itself. Throughput: one word per
// cycle while the skid is empty; a two-deep output stage keeps the input open while a
// result waits. Two line memories, each with one write and one read port, supply the rows.
// Reset: synchronous active-low aresetn restores the default rule (B3/S23) and a
// 1024 x 1024 grid and starts a fresh frame; line memories are not cleared.
module life_like_automaton_step_core #(
    parameter int MAX_WIDTH  = lla_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lla_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  lla_pkg::cfg_addr_t            cfg_addr,
    input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lla_pkg::TDATA_W-1:0]   s_tdata,   // [0] cell_in
    input  logic                          s_tuser,   // [0] flush
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lla_pkg::TDATA_W-1:0]   m_tdata,   // [0] next_cell
    output logic                          m_tlast
);
    import lla_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = $clog2(MAX_WIDTH + 2);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [MASK_W-1:0] birth_mask_reg, survive_mask_reg;
    logic [SIZE_W-1:0] grid_width_reg, grid_height_reg;
    logic              restart;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            birth_mask_reg   <= BIRTH_RESET;
            survive_mask_reg <= SURVIVE_RESET;
            grid_width_reg   <= SIZE_RESET;
            grid_height_reg  <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BIRTH_MASK:   birth_mask_reg   <= cfg_wdata[MASK_W-1:0];
                REG_SURVIVE_MASK: survive_mask_reg <= cfg_wdata[MASK_W-1:0];
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_GRID_HEIGHT:  grid_height_reg  <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = cfg_wr_en && (cfg_addr == REG_GRID_WIDTH || cfg_addr == REG_GRID_HEIGHT);

    // effective grid size: zero acts as one, clamp to MAX_WIDTH and MAX_HEIGHT
    logic [31:0]   w_full, h_full;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        w_full = {{(32-SIZE_W){1'b0}}, grid_width_reg};
        h_full = {{(32-SIZE_W){1'b0}}, grid_height_reg};
        if (w_full == 32'd0)
            w_full = 32'd1;
        else if (w_full > 32'(MAX_WIDTH))
            w_full = 32'(MAX_WIDTH);
        if (h_full == 32'd0)
            h_full = 32'd1;
        else if (h_full > 32'(MAX_HEIGHT))
            h_full = 32'(MAX_HEIGHT);
        w_eff = w_full[WW-1:0];
        h_eff = h_full[HW-1:0];
    end

    // frame counters
    logic [CW-1:0] wcol_reg, wcol_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [LW-1:0] lead_reg, lead_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic accept, in_drain, step, emit, col_last, out_col_last, out_row_last, out_last;
    logic cell_v;

    // window taps: lower row from the stream, middle and upper from the line memories
    logic mid_rd_reg, up_rd_reg;
    logic lo_d1_reg, lo_d2_reg, mid_d1_reg, mid_d2_reg, up_d1_reg, up_d2_reg;

    logic skid_valid_reg;
    logic main_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_drain = (in_row_reg == h_eff);
    // a flush word counts only while draining, a cell word only before
    assign step     = accept && (in_drain ? s_tuser : !s_tuser);
    assign cell_v   = !in_drain && s_tdata[0];
    assign col_last = (WW'(wcol_reg) == w_eff - WW'(1));
    assign emit     = step && (lead_reg == LW'(w_eff) + LW'(1));

    assign out_col_last = (WW'(out_col_reg) == w_eff - WW'(1));
    assign out_row_last = (HW'(out_row_reg) == h_eff - HW'(1));
    assign out_last     = out_col_last && out_row_last;

    always_comb begin
        wcol_next    = wcol_reg;
        in_row_next  = in_row_reg;
        lead_next    = lead_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (restart) begin
            wcol_next    = '0;
            in_row_next  = '0;
            lead_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (step) begin
            wcol_next = col_last ? '0 : wcol_reg + CW'(1);
            if (!in_drain && col_last)
                in_row_next = in_row_reg + HW'(1);
            if (!emit) begin
                lead_next = lead_reg + LW'(1);
            end else if (out_last) begin
                // frame done: start over
                wcol_next    = '0;
                in_row_next  = '0;
                lead_next    = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (out_col_last) begin
                out_col_next = '0;
                out_row_next = out_row_reg + RW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
            end
        end else begin
            // idle: hold every counter
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcol_reg    <= '0;
            in_row_reg  <= '0;
            lead_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            wcol_reg    <= wcol_next;
            in_row_reg  <= in_row_next;
            lead_reg    <= lead_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line memories: each delays the stream by one row; read the next column ahead
    logic mid_mem [MAX_WIDTH];
    logic up_mem  [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (step) begin
            mid_mem[wcol_reg] <= cell_v;
            up_mem[wcol_reg]  <= mid_rd_reg;
        end
        // forward the word just written when the next column is the same one
        if (step && wcol_next == wcol_reg) begin
            mid_rd_reg <= cell_v;
            up_rd_reg  <= mid_rd_reg;
        end else begin
            mid_rd_reg <= mid_mem[wcol_next];
            up_rd_reg  <= up_mem[wcol_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            lo_d1_reg  <= cell_v;
            lo_d2_reg  <= lo_d1_reg;
            mid_d1_reg <= mid_rd_reg;
            mid_d2_reg <= mid_d1_reg;
            up_d1_reg  <= up_rd_reg;
            up_d2_reg  <= up_d1_reg;
        end
    end

    // neighbour count with edges treated as dead
    logic       up_ok, dn_ok, lf_ok, rt_ok;
    logic [3:0] n_count;
    logic       next_cell;

    assign up_ok = (out_row_reg != '0);
    assign dn_ok = !out_row_last;
    assign lf_ok = (out_col_reg != '0);
    assign rt_ok = !out_col_last;

    always_comb begin
        n_count = 4'(up_ok & lf_ok & up_d2_reg)
                + 4'(up_ok & up_d1_reg)
                + 4'(up_ok & rt_ok & up_rd_reg)
                + 4'(lf_ok & mid_d2_reg)
                + 4'(rt_ok & mid_rd_reg)
                + 4'(dn_ok & lf_ok & lo_d2_reg)
                + 4'(dn_ok & lo_d1_reg)
                + 4'(dn_ok & rt_ok & cell_v);
        next_cell = mid_d1_reg ? survive_mask_reg[n_count] : birth_mask_reg[n_count];
    end

    // two-deep output: main register plus skid
    logic main_cell_reg, main_last_reg, skid_cell_reg, skid_last_reg;
    logic pop;

    assign pop = main_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (emit) begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_cell_reg <= skid_cell_reg;
                main_last_reg <= skid_last_reg;
            end
        end else if (emit) begin
            if (!main_valid_reg || pop) begin
                main_cell_reg <= next_cell;
                main_last_reg <= out_last;
            end else begin
                skid_cell_reg <= next_cell;
                skid_last_reg <= out_last;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(TDATA_W-1){1'b0}}, main_cell_reg};
    assign m_tlast  = main_last_reg;

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

    import lla_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_addr_t             cfg_addr  = REG_BIRTH_MASK;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // [0] cell_in
    logic                  s_tuser   = 1'b0; // [0] flush
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;          // [0] next_cell
    logic                  m_tlast;

    typedef struct {
        bit next_cell;
        bit frame_last;
    } gen_cell_t;

    class generation_checker;
        bit [MASK_W-1:0] birth_rule;
        bit [MASK_W-1:0] survive_rule;
        bit [SIZE_W-1:0] width_reg;
        bit [SIZE_W-1:0] height_reg;
        bit              line_rows [4][MAX_W];
        int              in_col, in_row, out_col, out_row, lead;
        gen_cell_t       expected_cells [$];
        int              errors;
        int              cells_checked;
        int              generations;

        function new();
            birth_rule    = BIRTH_RESET;
            survive_rule  = SURVIVE_RESET;
            width_reg     = SIZE_RESET;
            height_reg    = SIZE_RESET;
            errors        = 0;
            cells_checked = 0;
            generations   = 0;
            foreach (line_rows[r, c]) line_rows[r][c] = 1'b0;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            lead    = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_H) return MAX_H;
            return int'(height_reg);
        endfunction

        function void write_reg(cfg_addr_t addr, bit [CFG_DATA_W-1:0] val);
            case (addr)
                REG_BIRTH_MASK:   birth_rule = val[MASK_W-1:0];
                REG_SURVIVE_MASK: survive_rule = val[MASK_W-1:0];
                REG_GRID_WIDTH: begin
                    width_reg = val;
                    restart();
                end
                REG_GRID_HEIGHT: begin
                    height_reg = val;
                    restart();
                end
                default: ;
            endcase
        endfunction

        function int live_count(int r, int c, int w, int h);
            int total;
            total = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                        c + dc >= 0 && c + dc < w)
                        total += line_rows[(r + dr) & 3][c + dc];
                end
            end
            return total;
        endfunction

        // Update the window with one accepted word and queue the cell it completes.
        function void note_word(bit alive, bit flush);
            int        w, h, n;
            bit        self_alive;
            gen_cell_t res;
            w = eff_width();
            h = eff_height();
            if (in_row < h) begin
                if (flush) return;
                line_rows[in_row & 3][in_col] = alive;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end else if (!flush) begin
                return;
            end
            if (lead < w + 1) begin
                lead++;
                return;
            end
            n = live_count(out_row, out_col, w, h);
            self_alive = line_rows[out_row & 3][out_col];
            res.next_cell  = self_alive ? survive_rule[n] : birth_rule[n];
            res.frame_last = (out_row == h - 1) && (out_col == w - 1);
            expected_cells.insert(expected_cells.size(), res);
            if (res.frame_last) begin
                restart();
                generations++;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_cell(logic [TDATA_W-1:0] data, logic last);
            gen_cell_t          want;
            logic [TDATA_W-1:0] want_data;
            if (expected_cells.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: tdata=%h tlast=%b",
                         $time, data, last);
                return;
            end
            want = expected_cells.pop_front();
            want_data = {{(TDATA_W-1){1'b0}}, want.next_cell};
            cells_checked++;
            if (data !== want_data) begin
                errors++;
                $display("%0t: next_cell mismatch: expected tdata=%h actual tdata=%h",
                         $time, want_data, data);
            end
            if (last !== want.frame_last) begin
                errors++;
                $display("%0t: frame_last mismatch: expected %b actual %b",
                         $time, want.frame_last, last);
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    generation_checker sb = new();

    bit gaps_on     = 1'b1;
    bit hold_req    = 1'b0;
    int burst_left  = 0;
    int useful_words = 0;

    life_like_automaton_step_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_word(bit alive, bit flush);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-1){1'b0}}, alive};
        s_tuser  <= flush;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_word(alive, flush);
    endtask

    // Early flushes and late cells are mixed in as noise; the block must drop them.
    task automatic send_cells(int count, int live_pct, int noise_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(1'($urandom_range(0, 1)), 1'b1);
            send_word($urandom_range(0, 99) < live_pct, 1'b0);
            useful_words++;
        end
    endtask

    task automatic send_flushes(int count, int noise_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(1'($urandom_range(0, 1)), 1'b0);
            send_word(1'($urandom_range(0, 1)), 1'b1);
            useful_words++;
        end
    endtask

    task automatic run_frame(int w, int h, int live_pct, int noise_pct);
        send_cells(w * h, live_pct, noise_pct);
        send_flushes(w + 1, noise_pct);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // let words that produce no result clear the pipeline
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_word(cfg_addr_t addr, bit [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(addr, val);
    endtask

    task automatic set_masks(bit [MASK_W-1:0] birth, bit [MASK_W-1:0] survive);
        cfg_word(REG_BIRTH_MASK, CFG_DATA_W'(birth));
        cfg_word(REG_SURVIVE_MASK, CFG_DATA_W'(survive));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_size(bit [SIZE_W-1:0] w, bit [SIZE_W-1:0] h);
        cfg_word(REG_GRID_WIDTH, w);
        cfg_word(REG_GRID_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bit [MASK_W-1:0] rand_mask();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return MASK_W'($urandom_range(0, 511));
        endcase
    endfunction

    initial begin : result_sink
        int cyc, hold_cnt, mode;
        cyc = 0;
        hold_cnt = 0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_cell(m_tdata, m_tlast);
            if (hold_req) begin
                hold_cnt = 400;
                hold_req = 1'b0;
            end
            cyc++;
            if (cyc % 150 == 0) mode = $urandom_range(0, 3);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (cyc % 4) != 0;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        bit [8:0] blinker;
        int       w, h, live, split, base;
        blinker = 9'b010_010_010;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // vertical blinker under the reset rule, with a stray flush and a stray cell
        set_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            send_word(blinker[i], 1'b0);
            if (i == 2) send_word(1'b1, 1'b1);
        end
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b0);
        for (int i = 0; i < 3; i++) send_word(i[0], 1'b1);
        wait_drained();

        // zero width acts as one column
        set_masks(9'h1FF, 9'h000);
        set_size(0, 2);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);
        wait_drained();

        // zero height acts as one row
        set_masks(9'h000, 9'h1FF);
        set_size(4, 0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        for (int i = 0; i < 5; i++) send_word(i[0], 1'b1);
        wait_drained();

        // receiver holds off while the sender keeps offering words
        gaps_on = 1'b0;
        hold_req = 1'b1;
        set_masks(BIRTH_RESET, SURVIVE_RESET);
        set_size(16, 8);
        run_frame(16, 8, 40, 0);
        wait_drained();
        gaps_on = 1'b1;

        // rule change part way through a frame
        set_size(5, 4);
        send_cells(10, 50, 0);
        wait_drained();
        set_masks(rand_mask(), rand_mask());
        send_cells(10, 50, 0);
        send_flushes(6, 0);
        wait_drained();

        // size change abandons the frame in progress
        set_size(6, 5);
        send_cells(17, 50, 5);
        wait_drained();
        set_size(7, 3);
        run_frame(7, 3, 50, 5);
        wait_drained();

        // oversize sizes clamp to MAX_W and MAX_H; leave the frame unfinished
        gaps_on = 1'b0;
        set_masks(rand_mask(), rand_mask());
        set_size(11'h7FF, 11'h7FF);
        send_cells(MAX_W + 12, 35, 0);
        wait_drained();

        base = useful_words;
        while (useful_words - base < 120) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 1)) set_masks(rand_mask(), rand_mask());
            set_size(SIZE_W'((w == 1 && $urandom_range(0, 1)) ? 0 : w), SIZE_W'(h));
            gaps_on = $urandom_range(0, 3) != 0;
            live = $urandom_range(0, 100);
            case ($urandom_range(0, 9))
                0: send_cells($urandom_range(1, w * h), live, 5);
                1: begin
                    split = $urandom_range(0, w * h);
                    send_cells(split, live, 5);
                    wait_drained();
                    set_masks(rand_mask(), rand_mask());
                    send_cells(w * h - split, live, 5);
                    send_flushes(w + 1, 5);
                end
                2: begin
                    // two generations back to back with no drain between them
                    run_frame(w, h, live, 5);
                    run_frame(w, h, live, 5);
                end
                default: run_frame(w, h, live, 5);
            endcase
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (sb.pending() != 0) sb.errors++;
        $display("Checked %0d next-state cells over %0d generations from %0d frame words.",
                 sb.cells_checked, sb.generations, useful_words);
        $display("Grids from one cell to a clamped 1024-wide line, extreme rules, mid-frame changes.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
